FILE: rtl/core/block_sad_change_ranker_macros.svh
// assertion macros used by the checker file
`ifndef BLOCK_SAD_CHANGE_RANKER_MACROS_SVH
`define BLOCK_SAD_CHANGE_RANKER_MACROS_SVH

// same-cycle implication, off while reset is held
`define SADR_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("sadr check failed");

// next-cycle implication, off while reset is held
`define SADR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("sadr check failed");

// next-cycle implication that also runs during reset
`define SADR_ASSERT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("sadr reset check failed");

`endif

FILE: rtl/core/sadr_pkg.sv
`timescale 1ns / 1ps
package sadr_pkg;

  // request kinds on the input channel
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_POP   = 2'd2;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // field widths
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 10;
  localparam int LUMA_W    = 8;
  localparam int SAD_W     = 16;
  localparam int OUT_IDX_W = 6;
  localparam int KIND_W    = 2;

  localparam logic [SAD_W-1:0] SAD_MAX = '1;
  localparam logic [CFG_W-1:0] FRAME_RESET = 11'd1024;

  // reciprocal divide by the block size: exact for 11-bit dividends
  localparam int RECIP_SHIFT = 21;
  localparam int PROD_W      = 32;

  localparam int QUEUE_DEPTH = 4;

  // commands held in the queue between front and back
  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_PIXEL,
    CMD_POP
  } sadr_cmd_t;

  // back end sequencer
  typedef enum logic [2:0] {
    BK_SWEEP,
    BK_RUN,
    BK_SCAN,
    BK_SETTLE,
    BK_REPORT
  } sadr_bstate_t;

  // frame size registers as seen by the front end
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } sadr_frame_t;

endpackage

FILE: rtl/core/sadr_queue.sv
`timescale 1ns / 1ps
module sadr_queue #(
  parameter int W = 22
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] head
);

  localparam int PW = $clog2(sadr_pkg::QUEUE_DEPTH);

  logic [W-1:0] slot_r [sadr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == (PW+1)'(sadr_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/sadr_front.sv
`timescale 1ns / 1ps
module sadr_front #(
  parameter int BLOCK_SIZE   = 16,
  parameter int MAX_BLOCKS_Y = 64,
  parameter int NXW          = 7,
  parameter int NYW          = 7,
  parameter int IW           = 12,
  parameter int QW           = 22
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sadr_pkg::KIND_W-1:0]     in_kind,
  input  logic [sadr_pkg::COORD_W-1:0]    in_pixel_x,
  input  logic [sadr_pkg::COORD_W-1:0]    in_pixel_y,
  input  logic [sadr_pkg::LUMA_W-1:0]     in_ref_luma,
  input  logic [sadr_pkg::LUMA_W-1:0]     in_cur_luma,
  input  sadr_pkg::sadr_frame_t           frame,
  input  logic [NXW-1:0]                  nx,
  input  logic [NYW-1:0]                  ny,
  output logic                            push_valid,
  output logic [QW-1:0]                   push_data,
  input  logic                            q_full
);

  localparam int RECIP = (1 << sadr_pkg::RECIP_SHIFT) / BLOCK_SIZE + 1;
  localparam int CW    = sadr_pkg::COORD_W;
  localparam int LW    = sadr_pkg::LUMA_W;
  localparam int FW    = sadr_pkg::CFG_W;

  logic [sadr_pkg::PROD_W-1:0] x_prod;
  logic [sadr_pkg::PROD_W-1:0] y_prod;
  logic [CW-1:0]               col_q;
  logic [CW-1:0]               row_q;
  logic                        in_frame;
  logic [LW-1:0]               diff;
  logic                        adv;

  logic                        s1_v_r;
  logic [sadr_pkg::KIND_W-1:0] s1_kind_r;
  logic [CW-1:0]               s1_col_r;
  logic [CW-1:0]               s1_row_r;
  logic                        s1_inf_r;
  logic [LW-1:0]               s1_diff_r;

  logic                        col_ok;
  logic                        row_ok;
  logic [sadr_pkg::PROD_W-1:0] idx_w;
  logic [IW-1:0]               idx;
  logic                        keep;
  sadr_pkg::sadr_cmd_t         op;

  // block coordinates by reciprocal multiply, frame bounds, abs difference
  always_comb begin
    x_prod   = sadr_pkg::PROD_W'(in_pixel_x) * sadr_pkg::PROD_W'(RECIP);
    y_prod   = sadr_pkg::PROD_W'(in_pixel_y) * sadr_pkg::PROD_W'(RECIP);
    col_q    = x_prod[sadr_pkg::RECIP_SHIFT +: CW];
    row_q    = y_prod[sadr_pkg::RECIP_SHIFT +: CW];
    in_frame = ({1'b0, in_pixel_x} < frame.width) && ({1'b0, in_pixel_y} < frame.height);
    diff     = (in_ref_luma > in_cur_luma) ? (in_ref_luma - in_cur_luma)
                                           : (in_cur_luma - in_ref_luma);
  end

  assign adv      = !s1_v_r || !q_full;
  assign in_ready = adv;

  // first stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  // first stage payload
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s1_kind_r <= in_kind;
      s1_col_r  <= col_q;
      s1_row_r  <= row_q;
      s1_inf_r  <= in_frame;
      s1_diff_r <= diff;
    end
  end

  // full-block check and flat block index
  always_comb begin
    col_ok = FW'(s1_col_r) < FW'(nx);
    row_ok = FW'(s1_row_r) < FW'(ny);
    idx_w  = sadr_pkg::PROD_W'(s1_col_r) * sadr_pkg::PROD_W'(MAX_BLOCKS_Y)
           + sadr_pkg::PROD_W'(s1_row_r);
    idx    = IW'(idx_w);
  end

  // classify: drop unused kinds and pixels outside the full blocks
  always_comb begin
    keep = 1'b0;
    op   = sadr_pkg::CMD_PIXEL;
    unique case (s1_kind_r)
      sadr_pkg::KIND_CLEAR: begin
        keep = 1'b1;
        op   = sadr_pkg::CMD_CLEAR;
      end
      sadr_pkg::KIND_PIXEL: begin
        keep = s1_inf_r && col_ok && row_ok;
        op   = sadr_pkg::CMD_PIXEL;
      end
      sadr_pkg::KIND_POP: begin
        keep = 1'b1;
        op   = sadr_pkg::CMD_POP;
      end
      default: begin
        keep = 1'b0;
        op   = sadr_pkg::CMD_PIXEL;
      end
    endcase
  end

  assign push_valid = s1_v_r && keep && !q_full;
  assign push_data  = {op, idx, s1_diff_r};

endmodule

FILE: rtl/core/sadr_back.sv
`timescale 1ns / 1ps
module sadr_back #(
  parameter int MAX_BLOCKS_X = 64,
  parameter int MAX_BLOCKS_Y = 64,
  parameter int NXW          = 7,
  parameter int NYW          = 7,
  parameter int IW           = 12,
  parameter int QW           = 22
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  logic [QW-1:0]                     q_head,
  output logic                              q_pop,
  input  logic [NXW-1:0]                    nx,
  input  logic [NYW-1:0]                    ny,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [sadr_pkg::OUT_IDX_W-1:0]    out_block_col,
  output logic [sadr_pkg::OUT_IDX_W-1:0]    out_block_row,
  output logic [sadr_pkg::SAD_W-1:0]        out_block_sad
);

  localparam int NB = MAX_BLOCKS_X * MAX_BLOCKS_Y;
  localparam int XW = (MAX_BLOCKS_X > 1) ? $clog2(MAX_BLOCKS_X) : 1;
  localparam int YW = (MAX_BLOCKS_Y > 1) ? $clog2(MAX_BLOCKS_Y) : 1;
  localparam int LW = sadr_pkg::LUMA_W;
  localparam int SW = sadr_pkg::SAD_W;

  sadr_pkg::sadr_bstate_t state_r;
  sadr_pkg::sadr_bstate_t state_nxt;

  // queue head fields
  sadr_pkg::sadr_cmd_t q_op;
  logic [IW-1:0]       q_idx;
  logic [LW-1:0]       q_diff;
  logic                q_take;

  // sweep and scan position
  logic [IW-1:0] a_r;
  logic [XW-1:0] c_r;
  logic [YW-1:0] r_r;
  logic          a_last;
  logic          mark_r;

  logic sweep_on;
  logic scan_on;
  logic out_free;
  logic report_fire;

  // block memories
  logic [SW-1:0] sad_mem [NB];
  logic          pend_mem [NB];
  logic [SW-1:0] sad_q_r;
  logic          pend_q_r;
  logic [IW-1:0] sad_ra;
  logic          sad_we;
  logic [IW-1:0] sad_wa;
  logic [SW-1:0] sad_wd;
  logic          pend_we;
  logic [IW-1:0] pend_wa;
  logic          pend_wd;

  // pixel read-modify-write
  logic          px_v_r;
  logic [IW-1:0] px_idx_r;
  logic [LW-1:0] px_diff_r;
  logic [SW-1:0] px_base;
  logic [SW:0]   px_sum_w;
  logic [SW-1:0] px_sum;
  logic          last_we_r;
  logic [IW-1:0] last_a_r;
  logic [SW-1:0] last_d_r;

  // scan compare stage
  logic          rd_v_r;
  logic [IW-1:0] rd_a_r;
  logic [XW-1:0] rd_c_r;
  logic [YW-1:0] rd_r_r;
  logic          have_r;
  logic [IW-1:0] best_a_r;
  logic [XW-1:0] best_c_r;
  logic [YW-1:0] best_r_r;
  logic [SW-1:0] best_s_r;

  // output register
  logic                           out_valid_r;
  logic                           out_found_r;
  logic [sadr_pkg::OUT_IDX_W-1:0] out_col_r;
  logic [sadr_pkg::OUT_IDX_W-1:0] out_row_r;
  logic [SW-1:0]                  out_sad_r;

  assign q_op   = sadr_pkg::sadr_cmd_t'(q_head[QW-1 -: 2]);
  assign q_idx  = q_head[LW +: IW];
  assign q_diff = q_head[LW-1:0];
  assign a_last = (a_r == IW'(NB - 1));
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sadr_pkg::BK_SWEEP: begin
        if (a_last) begin
          state_nxt = sadr_pkg::BK_RUN;
        end
      end
      sadr_pkg::BK_RUN: begin
        if (!q_empty && q_op == sadr_pkg::CMD_CLEAR) begin
          state_nxt = sadr_pkg::BK_SWEEP;
        end else if (!q_empty && q_op == sadr_pkg::CMD_POP) begin
          state_nxt = sadr_pkg::BK_SCAN;
        end
      end
      sadr_pkg::BK_SCAN: begin
        if (a_last) begin
          state_nxt = sadr_pkg::BK_SETTLE;
        end
      end
      sadr_pkg::BK_SETTLE: begin
        state_nxt = sadr_pkg::BK_REPORT;
      end
      sadr_pkg::BK_REPORT: begin
        if (out_free) begin
          state_nxt = sadr_pkg::BK_RUN;
        end
      end
      default: begin
        state_nxt = sadr_pkg::BK_RUN;
      end
    endcase
  end

  // state outputs
  always_comb begin
    sweep_on    = (state_r == sadr_pkg::BK_SWEEP);
    scan_on     = (state_r == sadr_pkg::BK_SCAN);
    q_take      = (state_r == sadr_pkg::BK_RUN) && !q_empty;
    report_fire = (state_r == sadr_pkg::BK_REPORT) && out_free;
  end

  assign q_pop = q_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sadr_pkg::BK_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // position counters, column-major order with row fastest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r    <= '0;
      c_r    <= '0;
      r_r    <= '0;
      mark_r <= 1'b0;
    end else begin
      if (q_take && q_op == sadr_pkg::CMD_CLEAR) begin
        mark_r <= 1'b1;
      end
      if (sweep_on || scan_on) begin
        if (a_last) begin
          a_r <= '0;
          c_r <= '0;
          r_r <= '0;
        end else begin
          a_r <= a_r + 1'b1;
          if (r_r == YW'(MAX_BLOCKS_Y - 1)) begin
            r_r <= '0;
            c_r <= c_r + 1'b1;
          end else begin
            r_r <= r_r + 1'b1;
          end
        end
      end
    end
  end

  // pixel update with forwarding of the previous cycle's write
  always_comb begin
    px_base  = (last_we_r && last_a_r == px_idx_r) ? last_d_r : sad_q_r;
    px_sum_w = {1'b0, px_base} + (SW+1)'(px_diff_r);
    px_sum   = px_sum_w[SW] ? sadr_pkg::SAD_MAX : px_sum_w[SW-1:0];
  end

  // memory port selection
  always_comb begin
    sad_ra  = scan_on ? a_r : q_idx;
    sad_we  = sweep_on || px_v_r;
    sad_wa  = sweep_on ? a_r : px_idx_r;
    sad_wd  = sweep_on ? '0 : px_sum;
    pend_we = sweep_on || (report_fire && have_r);
    pend_wa = sweep_on ? a_r : best_a_r;
    pend_wd = sweep_on && mark_r && (NXW'(c_r) < nx) && (NYW'(r_r) < ny);
  end

  // block sums
  always_ff @(posedge clk) begin
    if (sad_we) begin
      sad_mem[sad_wa] <= sad_wd;
    end
    sad_q_r <= sad_mem[sad_ra];
  end

  // pending marks
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    pend_q_r <= pend_mem[a_r];
  end

  // pixel pipeline and last-write record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_v_r    <= 1'b0;
      last_we_r <= 1'b0;
    end else begin
      px_v_r    <= q_take && q_op == sadr_pkg::CMD_PIXEL;
      last_we_r <= sad_we;
    end
  end

  always_ff @(posedge clk) begin
    px_idx_r  <= q_idx;
    px_diff_r <= q_diff;
    last_a_r  <= sad_wa;
    last_d_r  <= sad_wd;
    rd_a_r    <= a_r;
    rd_c_r    <= c_r;
    rd_r_r    <= r_r;
  end

  // running maximum over pending blocks, first one wins on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      have_r   <= 1'b0;
      best_a_r <= '0;
      best_c_r <= '0;
      best_r_r <= '0;
      best_s_r <= '0;
    end else begin
      rd_v_r <= scan_on;
      if (q_take && q_op == sadr_pkg::CMD_POP) begin
        have_r   <= 1'b0;
        best_a_r <= '0;
        best_c_r <= '0;
        best_r_r <= '0;
        best_s_r <= '0;
      end else if (rd_v_r && pend_q_r && (!have_r || sad_q_r > best_s_r)) begin
        have_r   <= 1'b1;
        best_a_r <= rd_a_r;
        best_c_r <= rd_c_r;
        best_r_r <= rd_r_r;
        best_s_r <= sad_q_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (report_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report_fire) begin
      out_found_r <= have_r;
      out_col_r   <= sadr_pkg::OUT_IDX_W'(best_c_r);
      out_row_r   <= sadr_pkg::OUT_IDX_W'(best_r_r);
      out_sad_r   <= best_s_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_block_col = out_col_r;
  assign out_block_row = out_row_r;
  assign out_block_sad = out_sad_r;

endmodule

FILE: rtl/core/block_sad_change_ranker.sv
`timescale 1ns / 1ps
// Ranks the full square blocks of a frame by the sum of absolute luma differences.
// Input channel (in_valid/in_ready): in_kind selects clear, pixel pair or pop.
// Clear zeroes all sums and marks every full block pending; pixel pairs add
// |ref - cur| into their block's sum (saturating); a pop returns the pending block
// with the largest sum on the output channel (out_valid/out_ready) and unmarks it.
// Only pops produce a request on the output; out_found is 0 when nothing is pending.
// Pixel pairs stream at one per cycle while the back end runs and the queue has room:
// a request passes the front register, then enters a four-entry queue; a pixel's
// sum is written from the back end's read register after the pair leaves the queue.
// A clear holds the back end while it sweeps every memory entry, one entry per cycle;
// a pop scans the same entries at the same rate, set by the single read port of the
// memories, then settles and reports, and holds the back end until its result is
// registered on the output.
// While the back end sweeps or scans, the front keeps taking requests until the
// queue fills, then drops in_ready.
// After reset the back end runs a clearing pass over every memory entry
// (all sums zero, nothing pending); the frame size resets to 1024 by 1024.
// A stalled output holds its result; the next report waits until it is taken.
module block_sad_change_ranker #(
  parameter int BLOCK_SIZE   = 16,
  parameter int MAX_BLOCKS_X = 64,
  parameter int MAX_BLOCKS_Y = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sadr_pkg::KIND_W-1:0]       in_kind,
  input  logic [sadr_pkg::COORD_W-1:0]      in_pixel_x,
  input  logic [sadr_pkg::COORD_W-1:0]      in_pixel_y,
  input  logic [sadr_pkg::LUMA_W-1:0]       in_ref_luma,
  input  logic [sadr_pkg::LUMA_W-1:0]       in_cur_luma,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [sadr_pkg::OUT_IDX_W-1:0]    out_block_col,
  output logic [sadr_pkg::OUT_IDX_W-1:0]    out_block_row,
  output logic [sadr_pkg::SAD_W-1:0]        out_block_sad,
  input  logic                              cfg_we,
  input  logic [sadr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sadr_pkg::CFG_W-1:0]        cfg_data
);

  localparam int NB    = MAX_BLOCKS_X * MAX_BLOCKS_Y;
  localparam int IW    = (NB > 1) ? $clog2(NB) : 1;
  localparam int QW    = 2 + IW + sadr_pkg::LUMA_W;
  localparam int NXW   = $clog2(MAX_BLOCKS_X + 1);
  localparam int NYW   = $clog2(MAX_BLOCKS_Y + 1);
  localparam int RECIP = (1 << sadr_pkg::RECIP_SHIFT) / BLOCK_SIZE + 1;
  localparam int FW    = sadr_pkg::CFG_W;
  localparam int NX_RESET = (1024 / BLOCK_SIZE > MAX_BLOCKS_X) ? MAX_BLOCKS_X
                                                               : 1024 / BLOCK_SIZE;
  localparam int NY_RESET = (1024 / BLOCK_SIZE > MAX_BLOCKS_Y) ? MAX_BLOCKS_Y
                                                               : 1024 / BLOCK_SIZE;

  sadr_pkg::sadr_frame_t       frame_r;
  logic [NXW-1:0]              nx_r;
  logic [NYW-1:0]              ny_r;
  logic [sadr_pkg::PROD_W-1:0] cfg_prod;
  logic [FW-1:0]               cfg_q;
  logic [FW-1:0]               cfg_nx;
  logic [FW-1:0]               cfg_ny;

  logic          push_valid;
  logic [QW-1:0] push_data;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic [QW-1:0] q_head;

  // blocks across or down for the written size, capped at the array bounds
  always_comb begin
    cfg_prod = sadr_pkg::PROD_W'(cfg_data) * sadr_pkg::PROD_W'(RECIP);
    cfg_q    = cfg_prod[sadr_pkg::RECIP_SHIFT +: FW];
    cfg_nx   = (cfg_q > FW'(MAX_BLOCKS_X)) ? FW'(MAX_BLOCKS_X) : cfg_q;
    cfg_ny   = (cfg_q > FW'(MAX_BLOCKS_Y)) ? FW'(MAX_BLOCKS_Y) : cfg_q;
  end

  // frame size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r.width  <= sadr_pkg::FRAME_RESET;
      frame_r.height <= sadr_pkg::FRAME_RESET;
      nx_r           <= NXW'(NX_RESET);
      ny_r           <= NYW'(NY_RESET);
    end else if (cfg_we) begin
      if (cfg_index == sadr_pkg::REG_FRAME_WIDTH) begin
        frame_r.width <= cfg_data;
        nx_r          <= NXW'(cfg_nx);
      end else if (cfg_index == sadr_pkg::REG_FRAME_HEIGHT) begin
        frame_r.height <= cfg_data;
        ny_r           <= NYW'(cfg_ny);
      end
    end
  end

  // request classification
  sadr_front #(
    .BLOCK_SIZE   (BLOCK_SIZE),
    .MAX_BLOCKS_Y (MAX_BLOCKS_Y),
    .NXW          (NXW),
    .NYW          (NYW),
    .IW           (IW),
    .QW           (QW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_pixel_x  (in_pixel_x),
    .in_pixel_y  (in_pixel_y),
    .in_ref_luma (in_ref_luma),
    .in_cur_luma (in_cur_luma),
    .frame       (frame_r),
    .nx          (nx_r),
    .ny          (ny_r),
    .push_valid  (push_valid),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  // command queue between front and back
  sadr_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // block memories, sweep, scan and result register
  sadr_back #(
    .MAX_BLOCKS_X (MAX_BLOCKS_X),
    .MAX_BLOCKS_Y (MAX_BLOCKS_Y),
    .NXW          (NXW),
    .NYW          (NYW),
    .IW           (IW),
    .QW           (QW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .nx            (nx_r),
    .ny            (ny_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_block_col (out_block_col),
    .out_block_row (out_block_row),
    .out_block_sad (out_block_sad)
  );

endmodule

FILE: rtl/core/sadr_checker.sv
`timescale 1ns / 1ps
`include "block_sad_change_ranker_macros.svh"
module sadr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_found,
  input logic [sadr_pkg::OUT_IDX_W-1:0] out_block_col,
  input logic [sadr_pkg::OUT_IDX_W-1:0] out_block_row,
  input logic [sadr_pkg::SAD_W-1:0]     out_block_sad
);

  // a stalled result holds
  `SADR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_block_col) && $stable(out_block_row) && $stable(out_block_sad))

  // a result only leaves when taken
  `SADR_ASSERT_NOW(a_out_drop, clk, rst_n, $fell(out_valid) && $past(rst_n), $past(out_ready))

  // an empty pop reports all-zero fields
  `SADR_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && !out_found, out_block_col == '0 && out_block_row == '0 && out_block_sad == '0)

  // reset empties the result register
  `SADR_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind block_sad_change_ranker sadr_checker u_sadr_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// one ranked block as it leaves the result channel
typedef struct packed {
  logic                           found;
  logic [sadr_pkg::OUT_IDX_W-1:0] col;
  logic [sadr_pkg::OUT_IDX_W-1:0] row;
  logic [sadr_pkg::SAD_W-1:0]     sad;
} ranked_block_t;

// tracks per-block sums and pending marks, and queues the block each pop should return
class sad_rank_scoreboard;
  localparam int BLOCK_PIX = 16;
  localparam int COLS_MAX  = 64;
  localparam int ROWS_MAX  = 64;

  logic [sadr_pkg::SAD_W-1:0] block_sum [COLS_MAX*ROWS_MAX];
  bit                         block_marked [COLS_MAX*ROWS_MAX];
  int                         frame_w;
  int                         frame_h;
  ranked_block_t              expected_pops [$];
  int                         mismatches;
  int                         pops_checked;
  int                         pops_found;

  function new();
    frame_w = int'(sadr_pkg::FRAME_RESET);
    frame_h = int'(sadr_pkg::FRAME_RESET);
    foreach (block_sum[i]) begin
      block_sum[i]    = '0;
      block_marked[i] = 1'b0;
    end
    mismatches   = 0;
    pops_checked = 0;
    pops_found   = 0;
  endfunction

  // full blocks across and down, capped at the store size
  function int full_cols();
    return (frame_w / BLOCK_PIX > COLS_MAX) ? COLS_MAX : frame_w / BLOCK_PIX;
  endfunction

  function int full_rows();
    return (frame_h / BLOCK_PIX > ROWS_MAX) ? ROWS_MAX : frame_h / BLOCK_PIX;
  endfunction

  // apply one accepted request to the block state
  function void note_request(logic [sadr_pkg::KIND_W-1:0] kind,
                             logic [sadr_pkg::COORD_W-1:0] px,
                             logic [sadr_pkg::COORD_W-1:0] py,
                             logic [sadr_pkg::LUMA_W-1:0] ref_l,
                             logic [sadr_pkg::LUMA_W-1:0] cur_l);
    int                         col;
    int                         row;
    int                         idx;
    int                         diff;
    int                         total;
    int                         best_idx;
    logic [sadr_pkg::SAD_W-1:0] best;
    bit                         have;
    ranked_block_t              res;
    unique case (kind)
      sadr_pkg::KIND_CLEAR: begin
        foreach (block_sum[i]) begin
          block_sum[i]    = '0;
          block_marked[i] = (i / ROWS_MAX < full_cols()) && (i % ROWS_MAX < full_rows());
        end
      end
      sadr_pkg::KIND_PIXEL: begin
        col = int'(px) / BLOCK_PIX;
        row = int'(py) / BLOCK_PIX;
        // outside the frame or in a partial edge block: dropped
        if (int'(px) < frame_w && int'(py) < frame_h &&
            col < full_cols() && row < full_rows()) begin
          idx  = col * ROWS_MAX + row;
          diff = int'(ref_l) - int'(cur_l);
          if (diff < 0) diff = -diff;
          total = int'(block_sum[idx]) + diff;
          block_sum[idx] = (total > 65535) ? '1 : sadr_pkg::SAD_W'(total);
        end
      end
      sadr_pkg::KIND_POP: begin
        // column-major scan, strict greater keeps the lowest column then row on ties
        res      = '0;
        have     = 1'b0;
        best     = '0;
        best_idx = 0;
        foreach (block_sum[i]) begin
          if (block_marked[i] && (!have || block_sum[i] > best)) begin
            have     = 1'b1;
            best     = block_sum[i];
            best_idx = i;
          end
        end
        if (have) begin
          block_marked[best_idx] = 1'b0;
          res.found = 1'b1;
          res.col   = sadr_pkg::OUT_IDX_W'(best_idx / ROWS_MAX);
          res.row   = sadr_pkg::OUT_IDX_W'(best_idx % ROWS_MAX);
          res.sad   = best;
        end
        expected_pops.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function void report(string what, ranked_block_t want, ranked_block_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected found=%0d col=%0d row=%0d sad=%0d", what,
               want.found, want.col, want.row, want.sad);
      $display("  got found=%0d col=%0d row=%0d sad=%0d",
               got.found, got.col, got.row, got.sad);
    end
  endfunction

  // compare one result against the oldest pop
  function void check_result(ranked_block_t got);
    ranked_block_t want;
    if (expected_pops.size() == 0) begin
      report("result with no pop outstanding", '0, got);
      return;
    end
    want = expected_pops.pop_front();
    pops_checked++;
    if (want.found) pops_found++;
    if (got.found !== want.found || got.col !== want.col ||
        got.row !== want.row || got.sad !== want.sad)
      report("ranked block differs", want, got);
  endfunction
endclass

module testbench;
  localparam int QUIET_LIMIT = 100000;
  localparam logic [sadr_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                           clk           = 1'b0;
  logic                           rst_n         = 1'b0;
  logic                           in_valid      = 1'b0;
  logic                           in_ready;
  logic [sadr_pkg::KIND_W-1:0]    in_kind       = sadr_pkg::KIND_CLEAR;
  logic [sadr_pkg::COORD_W-1:0]   in_pixel_x    = '0;
  logic [sadr_pkg::COORD_W-1:0]   in_pixel_y    = '0;
  logic [sadr_pkg::LUMA_W-1:0]    in_ref_luma   = '0;
  logic [sadr_pkg::LUMA_W-1:0]    in_cur_luma   = '0;
  logic                           out_valid;
  logic                           out_ready     = 1'b0;
  logic                           out_found;
  logic [sadr_pkg::OUT_IDX_W-1:0] out_block_col;
  logic [sadr_pkg::OUT_IDX_W-1:0] out_block_row;
  logic [sadr_pkg::SAD_W-1:0]     out_block_sad;
  logic                           cfg_we        = 1'b0;
  logic [sadr_pkg::CFG_IDX_W-1:0] cfg_index     = sadr_pkg::REG_FRAME_WIDTH;
  logic [sadr_pkg::CFG_W-1:0]     cfg_data      = '0;

  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int quiet_cycles  = 0;
  int n_pixels      = 0;
  int n_clears      = 0;
  int n_pops        = 0;
  int n_unused      = 0;

  sad_rank_scoreboard sb;

  block_sad_change_ranker u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_ref_luma   (in_ref_luma),
    .in_cur_luma   (in_cur_luma),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_block_col (out_block_col),
    .out_block_row (out_block_row),
    .out_block_sad (out_block_sad),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_found, out_block_col, out_block_row, out_block_sad});
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request on the input channel, after a random idle gap
  task automatic send_request(logic [sadr_pkg::KIND_W-1:0] kind,
                              logic [sadr_pkg::COORD_W-1:0] px,
                              logic [sadr_pkg::COORD_W-1:0] py,
                              logic [sadr_pkg::LUMA_W-1:0] ref_l,
                              logic [sadr_pkg::LUMA_W-1:0] cur_l);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < in_gap_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_pixel_x  <= px;
    in_pixel_y  <= py;
    in_ref_luma <= ref_l;
    in_cur_luma <= cur_l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(kind, px, py, ref_l, cur_l);
    unique case (kind)
      sadr_pkg::KIND_CLEAR: n_clears++;
      sadr_pkg::KIND_PIXEL: n_pixels++;
      sadr_pkg::KIND_POP:   n_pops++;
      default:              n_unused++;
    endcase
  endtask

  // drop valid and wait for every outstanding pop to come back
  task automatic drain_results(int settle);
    in_valid <= 1'b0;
    while (sb.expected_pops.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_frame(logic [sadr_pkg::CFG_W-1:0] w, logic [sadr_pkg::CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= sadr_pkg::REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= sadr_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.frame_w = int'(w);
    sb.frame_h = int'(h);
  endtask

  // pixel pair, mostly inside the frame, with extreme and equal lumas mixed in
  task automatic send_random_pixel(int w, int h);
    logic [sadr_pkg::COORD_W-1:0] px;
    logic [sadr_pkg::COORD_W-1:0] py;
    logic [sadr_pkg::LUMA_W-1:0]  a;
    logic [sadr_pkg::LUMA_W-1:0]  b;
    if ($urandom_range(0, 99) < 25) begin
      px = sadr_pkg::COORD_W'($urandom_range(0, 1023));
      py = sadr_pkg::COORD_W'($urandom_range(0, 1023));
    end else begin
      px = sadr_pkg::COORD_W'($urandom_range(0, w - 1));
      py = sadr_pkg::COORD_W'($urandom_range(0, h - 1));
    end
    case ($urandom_range(0, 4))
      0: begin
        a = '1;
        b = '0;
      end
      1: begin
        a = '0;
        b = '1;
      end
      2: begin
        a = sadr_pkg::LUMA_W'($urandom_range(0, 255));
        b = a;
      end
      default: begin
        a = sadr_pkg::LUMA_W'($urandom_range(0, 255));
        b = sadr_pkg::LUMA_W'($urandom_range(0, 255));
      end
    endcase
    send_request(sadr_pkg::KIND_PIXEL, px, py, a, b);
  endtask

  // rounds of optional clear, pixel burst, pops; ends with a pop so the block is idle after drain
  task automatic run_phase(int w, int h, int gap_pct, int stall_pct, int rounds,
                           bit saturate);
    int r;
    int n_pix;
    write_frame(sadr_pkg::CFG_W'(w), sadr_pkg::CFG_W'(h));
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    for (r = 0; r < rounds; r++) begin
      if ($urandom_range(0, 9) < 7 || (saturate && r == 0))
        send_request(sadr_pkg::KIND_CLEAR, '0, '0, '0, '0);
      // drive one block past the top of its sum
      if (saturate && r == 0) begin
        repeat (280)
          send_request(sadr_pkg::KIND_PIXEL, sadr_pkg::COORD_W'($urandom_range(0, 15)),
                       sadr_pkg::COORD_W'($urandom_range(0, 15)), '1, '0);
      end
      n_pix = $urandom_range(5, 35);
      repeat (n_pix) begin
        if ($urandom_range(0, 99) < 8)
          send_request(KIND_UNUSED, sadr_pkg::COORD_W'($urandom),
                       sadr_pkg::COORD_W'($urandom), sadr_pkg::LUMA_W'($urandom),
                       sadr_pkg::LUMA_W'($urandom));
        send_random_pixel(w, h);
      end
      repeat ($urandom_range(1, 3))
        send_request(sadr_pkg::KIND_POP, sadr_pkg::COORD_W'($urandom),
                     sadr_pkg::COORD_W'($urandom), sadr_pkg::LUMA_W'($urandom),
                     sadr_pkg::LUMA_W'($urandom));
    end
    drain_results(16);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty pop, far corners, tie order, unused kind, sum into a popped block
    send_request(sadr_pkg::KIND_POP, '0, '0, '0, '0);
    send_request(sadr_pkg::KIND_CLEAR, '0, '0, '0, '0);
    send_request(sadr_pkg::KIND_PIXEL, 10'd1023, 10'd1023, 8'd255, 8'd0);
    send_request(sadr_pkg::KIND_PIXEL, 10'd0, 10'd0, 8'd0, 8'd255);
    send_request(sadr_pkg::KIND_PIXEL, 10'd17, 10'd0, 8'd10, 8'd10);
    send_request(sadr_pkg::KIND_PIXEL, 10'd512, 10'd768, 8'd170, 8'd85);
    send_request(KIND_UNUSED, 10'd1023, 10'd1023, 8'd255, 8'd255);
    repeat (4) send_request(sadr_pkg::KIND_POP, '0, '0, '0, '0);
    send_request(sadr_pkg::KIND_PIXEL, 10'd0, 10'd0, 8'd255, 8'd0);
    send_request(sadr_pkg::KIND_POP, '0, '0, '0, '0);
    drain_results(16);

    // 40 x 20 frame: partial edge blocks and pixels outside the frame
    write_frame(11'd40, 11'd20);
    send_request(sadr_pkg::KIND_CLEAR, '0, '0, '0, '0);
    send_request(sadr_pkg::KIND_PIXEL, 10'd39, 10'd5, 8'd255, 8'd0);
    send_request(sadr_pkg::KIND_PIXEL, 10'd5, 10'd19, 8'd255, 8'd0);
    send_request(sadr_pkg::KIND_PIXEL, 10'd40, 10'd0, 8'd255, 8'd0);
    send_request(sadr_pkg::KIND_PIXEL, 10'd0, 10'd20, 8'd255, 8'd0);
    send_request(sadr_pkg::KIND_PIXEL, 10'd20, 10'd3, 8'd0, 8'd200);
    repeat (3) send_request(sadr_pkg::KIND_POP, '0, '0, '0, '0);
    drain_results(16);

    // random phases over frame sizes and idle patterns
    run_phase(1024, 1024, 0, 0, 6, 1'b0);
    run_phase(32, 32, 55, 0, 5, 1'b1);
    run_phase(100, 50, 0, 55, 6, 1'b0);
    run_phase(15, 1024, 10, 10, 4, 1'b0);
    run_phase(1, 1, 0, 0, 3, 1'b0);
    run_phase(1024, 16, 55, 0, 5, 1'b0);
    run_phase(17, 33, 0, 55, 5, 1'b0);
    run_phase(1024, 1024, 10, 10, 6, 1'b0);

    // let a full scan time pass to catch any stray result
    repeat (4200) @(posedge clk);

    $display("sent %0d requests: %0d pixel pairs, %0d clears, %0d pops, %0d unused kind",
             n_pixels + n_clears + n_pops + n_unused, n_pixels, n_clears, n_pops, n_unused);
    $display("checked %0d pops (%0d returned a block) across 8 frame sizes, %0d mismatches",
             sb.pops_checked, sb.pops_found, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_pops.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
